// ===== hw/rtl/spherical_harmonic_table_defines.svh =====
// Assertion macros for the spherical harmonic table.
// Used by the top level only; expects clk and rst in scope.
`ifndef SPHERICAL_HARMONIC_TABLE_DEFINES_SVH
`define SPHERICAL_HARMONIC_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sht_pkg.sv =====
// Package for the spherical harmonic table: types, constants,
// recurrence coefficient tables and fixed-point helper functions. No dependencies.
package sht_pkg;

  localparam int MAX_DEG      = 8;
  localparam int TAB_DEPTH    = 36;
  localparam int TAB_AW       = 6;
  localparam int TAG_AW       = 4;
  localparam int HORNER_TERMS = 7;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [45:0] PI_Q44  = 46'h3243_F6A8_885A;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam logic signed [35:0] SAT_HI  = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SAT_LO  = -36'sh0_8000_0000;
  localparam logic signed [34:0] OUT_HI  = 35'sd65536;
  localparam logic signed [34:0] OUT_LO  = -35'sd65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_DRAIN, ST_READ, ST_MUL1, ST_MUL2, ST_SUB, ST_PHASE, ST_EMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_AW-1:0] angle;
    logic              cos_sel;
    logic [14:0]       r;
  } trig_req_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_AW-1:0] angle;
    logic              cos_sel;
    logic [30:0]       value;
  } trig_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_AW-1:0] angle;
    logic              cos_sel;
    logic [30:0]       x;
    logic [31:0]       x2;
    logic [30:0]       t;
  } horner_bus_t;

  typedef logic [29:0] coef_t;
  typedef coef_t [TAB_DEPTH-1:0] coef_tab_t;

  // Largest r with r*r*den <= num * 2^56, i.e. sqrt(num/den) in Q28.
  function automatic coef_t root_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [95:0] target;
    logic [31:0] r;
    logic [31:0] trial;
    logic [95:0] sq;
    target = {32'd0, num} << 56;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      sq = 96'(trial) * 96'(trial) * 96'(den);
      if (sq <= target) r = trial;
    end
    return coef_t'(r);
  endfunction

  function automatic coef_tab_t build_coef(input logic sel_b);
    coef_tab_t   tab;
    int          idx;
    logic [63:0] nn;
    logic [63:0] mm;
    tab = '0;
    idx = 0;
    for (int n = 0; n < MAX_DEG; n++) begin
      for (int m = 0; m <= n; m++) begin
        nn = 64'(n);
        mm = 64'(m);
        if (n == 0) tab[idx] = '0;
        else if (m == n) tab[idx] = sel_b ? '0 : root_ratio(2 * mm - 1, 2 * mm);
        else if (m == n - 1) tab[idx] = sel_b ? '0 : root_ratio(2 * mm + 1, 64'd1);
        else if (sel_b) tab[idx] = root_ratio((nn - 1) * (nn - 1) - mm * mm, nn * nn - mm * mm);
        else tab[idx] = root_ratio((2 * nn - 1) * (2 * nn - 1), nn * nn - mm * mm);
        idx++;
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_A = build_coef(1'b0);
  localparam coef_tab_t COEF_B = build_coef(1'b1);

  // Product on magnitudes, truncating shift, sign applied after.
  function automatic logic signed [34:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b, input int sh);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    logic [33:0] pm;
    logic        neg;
    neg = a[32] ^ b[32];
    ua = a[32] ? 32'(-a) : 32'(a);
    ub = b[32] ? 32'(-b) : 32'(b);
    p = ua * ub;
    p = p >> sh;
    pm = p[33:0];
    return neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) res = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic signed [17:0] sat_out(input logic signed [34:0] v);
    logic signed [17:0] res;
    if (v > OUT_HI) res = 18'sd65536;
    else if (v < OUT_LO) res = -18'sd65536;
    else res = v[17:0];
    return res;
  endfunction

  function automatic logic signed [31:0] quad_sin(input logic [1:0] q,
                                                  input logic [30:0] s, input logic [30:0] c);
    logic signed [31:0] res;
    unique case (q)
      2'd0: res = $signed({1'b0, s});
      2'd1: res = $signed({1'b0, c});
      2'd2: res = -$signed({1'b0, s});
      2'd3: res = -$signed({1'b0, c});
    endcase
    return res;
  endfunction

  function automatic logic signed [31:0] quad_cos(input logic [1:0] q,
                                                  input logic [30:0] s, input logic [30:0] c);
    logic signed [31:0] res;
    unique case (q)
      2'd0: res = $signed({1'b0, c});
      2'd1: res = -$signed({1'b0, s});
      2'd2: res = -$signed({1'b0, c});
      2'd3: res = $signed({1'b0, s});
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/spherical_harmonic_table.sv =====
// Spherical harmonic table: per angle pair, 2*(2*POLES+1) sine feeds into a
// 24-stage sine chain, then each (n,m) entry goes through store read, two
// multiply steps, subtract and store, phase multiply and output load.
// One item at a time; a new item is taken once the last result is loaded.
// Synchronous active-high reset clears control state only.
`include "spherical_harmonic_table_defines.svh"
module spherical_harmonic_table
  import sht_pkg::*;
#(
  parameter int POLES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // polar_angle[14:0], azimuth_angle[30:15], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // degree[2:0], order[5:3], real_part[23:6],
                                 // imag_part[41:24], zero
  output logic        m_tlast    // last_of_table
);

  localparam int NDEG = 2 * POLES;
  localparam int NRES = NDEG * (NDEG + 1) / 2;
  localparam int NANG = NDEG + 1;
  localparam int IW   = $clog2(NRES);
  localparam int AW   = $clog2(NANG);
  localparam int CW   = $clog2(2 * NANG);

  state_t state, state_next;

  logic [14:0]   theta_q;
  logic [15:0]   phi_q;
  logic [15:0]   phase_acc;
  logic [CW-1:0] issue_cnt;
  logic [AW-1:0] jsel;
  logic [15:0]   angle;
  logic          drain_done;

  logic [30:0] raw_s [NANG];
  logic [30:0] raw_c [NANG];
  logic [1:0]  quad  [NANG];

  logic signed [31:0] mem [NRES];

  logic [IW-1:0]     idx;
  logic [2:0]        deg, ord;
  logic [IW-1:0]     a1, a2;
  logic [AW-1:0]     pidx;
  logic [TAB_AW-1:0] cidx;

  logic signed [31:0] rd1, rd2;
  logic signed [34:0] t1, bq, aq;
  logic signed [31:0] vq;
  logic signed [31:0] v_next;
  logic signed [35:0] v_wide;
  logic signed [17:0] re_q, im_q;
  logic signed [34:0] re_m, im_m;
  logic signed [31:0] th_s, th_c, cm, sm;
  logic               out_free;
  logic               last_entry;

  logic [2:0]         out_deg, out_ord;
  logic signed [17:0] out_re, out_im;

  trig_req_t req;
  trig_rsp_t rsp;

  sht_sine_chain u_chain (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_comb begin
    jsel = issue_cnt[CW-1:1];
    angle = (jsel == '0) ? {1'b0, theta_q} : phase_acc;
    req.valid = (state == ST_ISSUE);
    req.angle = TAG_AW'(jsel);
    req.cos_sel = issue_cnt[0];
    req.r = issue_cnt[0] ? QUARTER - {1'b0, angle[13:0]} : {1'b0, angle[13:0]};
    drain_done = rsp.valid && rsp.cos_sel && (rsp.angle == TAG_AW'(NANG - 1));

    th_s = quad_sin(quad[0], raw_s[0], raw_c[0]);
    th_c = quad_cos(quad[0], raw_s[0], raw_c[0]);
    pidx = AW'(ord) + AW'(1);
    sm = quad_sin(quad[pidx], raw_s[pidx], raw_c[pidx]);
    cm = quad_cos(quad[pidx], raw_s[pidx], raw_c[pidx]);

    a1 = (ord == deg) ? idx - IW'(deg) - IW'(1) : idx - IW'(deg);
    a2 = idx - (IW'(deg) << 1) + IW'(1);
    cidx = TAB_AW'(idx);

    if (deg == 3'd0) v_wide = 36'sd1 <<< 30;
    else if (ord == deg) v_wide = -{aq[34], aq};
    else if (ord == deg - 3'd1) v_wide = {aq[34], aq};
    else v_wide = {aq[34], aq} - {bq[34], bq};
    v_next = sat32(v_wide);

    re_m = mulq({vq[31], vq}, {cm[31], cm}, 44);
    im_m = mulq({vq[31], vq}, {sm[31], sm}, 44);
    if (ord[0]) begin
      re_m = -re_m;
      im_m = -im_m;
    end

    out_free = !m_tvalid || m_tready;
    last_entry = (idx == IW'(NRES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_ISSUE;
      ST_ISSUE: if (issue_cnt == CW'(2 * NANG - 1)) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_done) state_next = ST_READ;
      ST_READ:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_SUB;
      ST_SUB:   state_next = ST_PHASE;
      ST_PHASE: state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = last_entry ? ST_IDLE : ST_READ;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == ST_EMIT && out_free) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      theta_q <= s_tdata[14:0];
      phi_q <= s_tdata[30:15];
      phase_acc <= '0;
      issue_cnt <= '0;
      idx <= '0;
      deg <= '0;
      ord <= '0;
    end
    if (state == ST_ISSUE) begin
      issue_cnt <= issue_cnt + CW'(1);
      if (!issue_cnt[0]) quad[jsel] <= angle[15:14];
      if (issue_cnt[0] && jsel != '0) phase_acc <= phase_acc + phi_q;
    end
    if (rsp.valid) begin
      if (rsp.cos_sel) raw_c[rsp.angle[AW-1:0]] <= rsp.value;
      else raw_s[rsp.angle[AW-1:0]] <= rsp.value;
    end
    if (state == ST_MUL1) begin
      t1 <= mulq((ord == deg) ? {th_s[31], th_s} : {th_c[31], th_c}, {rd1[31], rd1}, 30);
      bq <= mulq($signed({3'b000, COEF_B[cidx]}), {rd2[31], rd2}, 28);
    end
    if (state == ST_MUL2) aq <= mulq($signed({3'b000, COEF_A[cidx]}), t1[32:0], 28);
    if (state == ST_SUB) vq <= v_next;
    if (state == ST_PHASE) begin
      re_q <= sat_out(re_m);
      im_q <= sat_out(im_m);
    end
    if (state == ST_EMIT && out_free) begin
      out_deg <= deg;
      out_ord <= ord;
      out_re <= re_q;
      out_im <= im_q;
      m_tlast <= last_entry;
      idx <= idx + IW'(1);
      if (ord == deg) begin
        deg <= deg + 3'd1;
        ord <= '0;
      end else begin
        ord <= ord + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUB) mem[idx] <= v_next;
    if (state == ST_READ) begin
      rd1 <= mem[a1];
      rd2 <= mem[a2];
    end
  end

  assign m_tdata = {6'd0, out_im, out_re, out_ord, out_deg};

  `SHT_ASSERT_IMP(a_last_pos, m_tvalid && m_tlast, (m_tdata[2:0] == 3'(NDEG - 1)) && (m_tdata[5:3] == m_tdata[2:0]), "last item not on final degree and order")
  `SHT_ASSERT_IMP(a_order_le_deg, m_tvalid, m_tdata[5:3] <= m_tdata[2:0], "order above degree")
  `SHT_ASSERT_IMP(a_sine_in_drain, rsp.valid, state == ST_DRAIN, "sine result outside drain")
  `SHT_ASSERT_NXT(a_intake_issue, s_tvalid && s_tready, state == ST_ISSUE, "intake did not start issue")

endmodule

// ===== hw/rtl/sht_horner_cell.sv =====
// One Horner step of the quarter-sine series: t <= 1 - (x2*t)/((2K)(2K+1)).
// Three register stages; depends on sht_pkg.
module sht_horner_cell
  import sht_pkg::*;
#(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  horner_bus_t din,
  output horner_bus_t dout
);

  localparam logic [63:0] DIV   = 64'(2 * K * (2 * K + 1));
  localparam logic [63:0] RECIP = (64'd1 << 32) / DIV;

  logic [62:0] prod_a;
  logic [61:0] prod_b;
  logic [39:0] qd;
  logic [32:0] rem;
  logic [29:0] q_fix;

  logic              va, vb;
  logic [TAG_AW-1:0] ang_a, ang_b;
  logic              cs_a, cs_b;
  logic [30:0]       x_a, x_b;
  logic [31:0]       x2_a, x2_b;
  logic [31:0]       p_a, p_b;
  logic [29:0]       q0_b;

  always_comb begin
    prod_a = din.x2 * din.t;
    prod_b = p_a * RECIP[29:0];
    qd = q0_b * DIV[7:0];
    rem = {1'b0, p_b} - qd[32:0];
    q_fix = (rem >= DIV[32:0]) ? q0_b + 30'd1 : q0_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      va <= din.valid;
      vb <= va;
      dout.valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    ang_a <= din.angle;
    cs_a <= din.cos_sel;
    x_a <= din.x;
    x2_a <= din.x2;
    p_a <= prod_a[61:30];
    ang_b <= ang_a;
    cs_b <= cs_a;
    x_b <= x_a;
    x2_b <= x2_a;
    p_b <= p_a;
    q0_b <= prod_b[61:32];
    dout.angle <= ang_b;
    dout.cos_sel <= cs_b;
    dout.x <= x_b;
    dout.x2 <= x2_b;
    dout.t <= ONE_Q30 - {1'b0, q_fix};
  end

endmodule

// ===== hw/rtl/sht_sine_chain.sv =====
// Pipelined quarter-sine unit: angle to radians, square, a row of Horner
// cells, final multiply and clamp. Depends on sht_pkg and sht_horner_cell.
module sht_sine_chain
  import sht_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  trig_req_t req,
  output trig_rsp_t rsp
);

  logic [60:0] xprod;
  logic [61:0] x2prod;
  logic [61:0] fprod;
  logic [30:0] tfin;

  logic              v0, v1;
  logic [TAG_AW-1:0] ang0, ang1;
  logic              cs0, cs1;
  logic [30:0]       x0, x1;
  logic [31:0]       x2_1;

  horner_bus_t h [HORNER_TERMS+1];

  always_comb begin
    xprod = req.r * PI_Q44;
    x2prod = x0 * x0;
    fprod = h[HORNER_TERMS].x * h[HORNER_TERMS].t;
    tfin = (fprod[60:30] > ONE_Q30) ? ONE_Q30 : fprod[60:30];
    h[0].valid = v1;
    h[0].angle = ang1;
    h[0].cos_sel = cs1;
    h[0].x = x1;
    h[0].x2 = x2_1;
    h[0].t = ONE_Q30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v0 <= req.valid;
      v1 <= v0;
      rsp.valid <= h[HORNER_TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    ang0 <= req.angle;
    cs0 <= req.cos_sel;
    x0 <= xprod[59:29];
    ang1 <= ang0;
    cs1 <= cs0;
    x1 <= x0;
    x2_1 <= x2prod[61:30];
    rsp.angle <= h[HORNER_TERMS].angle;
    rsp.cos_sel <= h[HORNER_TERMS].cos_sel;
    rsp.value <= tfin;
  end

  for (genvar g = 0; g < HORNER_TERMS; g++) begin : g_cell
    sht_horner_cell #(.K(HORNER_TERMS - g)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (h[g]),
      .dout(h[g+1])
    );
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for spherical_harmonic_table: drives angle pairs, predicts
// the 36-entry harmonic table per pair in fixed point, and checks each output item.
// Depends on the spherical_harmonic_table RTL and sht_pkg.
module testbench;
  import sht_pkg::*;

  typedef struct {
    logic [14:0] polar;
    logic [15:0] azimuth;
    bit          drain;
  } angle_pair_t;

  typedef struct {
    logic [2:0]         degree;
    logic [2:0]         order;
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic               last;
  } harmonic_t;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  angle_pair_t pending_pairs[$];
  harmonic_t   harmonics_due[$];
  longint      legendre_q[36];
  int          mismatches = 0;
  int          results_seen = 0;
  int          pairs_sent = 0;
  int          send_wait = 0;
  int          take_wait = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  spherical_harmonic_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  function automatic longint unsigned root_q28(longint unsigned num, longint unsigned den);
    longint unsigned target;
    longint unsigned res;
    longint unsigned trial;
    target = (num << 56) / den;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= target) res = trial;
    end
    return res;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_sine(longint unsigned r);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    one = 64'd1 << 30;
    x = (r * 64'h3243_F6A8_885A) >> 29;
    x2 = (x * x) >> 30;
    t = one;
    for (int k = 7; k >= 1; k--)
      t = one - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
    t = (x * t) >> 30;
    if (t > one) t = one;
    return longint'(t);
  endfunction

  task automatic turn_sin_cos(input logic [15:0] angle, output longint sv, output longint cv);
    longint s;
    longint c;
    s = quarter_sine(angle[13:0]);
    c = quarter_sine(16384 - angle[13:0]);
    case (angle[15:14])
      2'd0: begin sv = s; cv = c; end
      2'd1: begin sv = c; cv = -s; end
      2'd2: begin sv = -s; cv = -c; end
      default: begin sv = -c; cv = s; end
    endcase
  endtask

  task automatic predict_table(input angle_pair_t p);
    longint    x, s, v, cm, sm, re, im, t;
    int        base;
    harmonic_t h;
    turn_sin_cos({1'b0, p.polar}, s, x);
    for (int n = 0; n < 8; n++) begin
      base = n * (n + 1) / 2;
      for (int m = 0; m <= n; m++) begin
        if (n == 0) begin
          v = longint'(1) << 30;
        end else if (m == n) begin
          t = fx_mul(s, legendre_q[base - 1], 30);
          v = -fx_mul(root_q28(2 * m - 1, 2 * m), t, 28);
        end else if (m == n - 1) begin
          t = fx_mul(x, legendre_q[base - n + m], 30);
          v = fx_mul(root_q28(2 * m + 1, 1), t, 28);
        end else begin
          v = fx_mul(root_q28((2 * n - 1) * (2 * n - 1), n * n - m * m),
                     fx_mul(x, legendre_q[base - n + m], 30), 28)
              - fx_mul(root_q28((n - 1) * (n - 1) - m * m, n * n - m * m),
                       legendre_q[(n - 2) * (n - 1) / 2 + m], 28);
        end
        v = clamp(v, -64'sd2147483648, 64'sd2147483647);
        legendre_q[base + m] = v;
        turn_sin_cos(16'(m * p.azimuth), sm, cm);
        re = fx_mul(v, cm, 44);
        im = fx_mul(v, sm, 44);
        if (m % 2 == 1) begin
          re = -re;
          im = -im;
        end
        h.degree = 3'(n);
        h.order = 3'(m);
        h.re = 18'(clamp(re, -65536, 65536));
        h.im = 18'(clamp(im, -65536, 65536));
        h.last = (n == 7 && m == 7);
        harmonics_due.insert(harmonics_due.size(), h);
      end
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // sender
  always @(posedge clk) begin
    angle_pair_t p;
    logic        nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        p.polar = s_tdata[14:0];
        p.azimuth = s_tdata[30:15];
        predict_table(p);
        pairs_sent++;
        nxt_valid = 1'b0;
        send_wait = (pairs_sent > 120 && pairs_sent < 170) ? 0 : $urandom_range(0, 7);
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].drain && harmonics_due.size() != 0)) begin
          p = pending_pairs.pop_front();
          s_tdata <= {1'b0, p.azimuth, p.polar};
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= 1500) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    harmonic_t want;
    logic      nxt_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      nxt_ready = m_tready;
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (harmonics_due.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          want = harmonics_due.pop_front();
          if (m_tdata[2:0] != want.degree) report("degree", m_tdata[2:0], want.degree);
          if (m_tdata[5:3] != want.order) report("order", m_tdata[5:3], want.order);
          if ($signed(m_tdata[23:6]) != want.re) report("real", $signed(m_tdata[23:6]), want.re);
          if ($signed(m_tdata[41:24]) != want.im)
            report("imag", $signed(m_tdata[41:24]), want.im);
          if (m_tlast != want.last) report("last", m_tlast, want.last);
        end
        take_wait = (results_seen > 4000 && results_seen < 5500) ? 0 : $urandom_range(0, 7);
        nxt_ready = 1'b0;
      end
      if (take_wait > 0) begin
        take_wait--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      m_tready <= nxt_ready && (hold_left == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** spherical_harmonic_table: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    angle_pair_t p;
    logic [15:0] az_list[5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
    logic [14:0] pol_list[4] = '{15'd0, 15'd16384, 15'd32767, 15'd8192};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 5; j++) begin
        p.polar = pol_list[i];
        p.azimuth = az_list[j];
        p.drain = (i == 2 && j == 0);
        pending_pairs.insert(pending_pairs.size(), p);
      end
    end
    p.polar = 15'd16383;
    p.azimuth = 16'd16383;
    p.drain = 1'b0;
    pending_pairs.insert(pending_pairs.size(), p);
    for (int i = 0; i < 350; i++) begin
      p.polar = $urandom_range(0, 32767);
      p.azimuth = $urandom_range(0, 65535);
      p.drain = (i == 200);
      pending_pairs.insert(pending_pairs.size(), p);
    end
    for (int i = 0; i < 45; i++) legendre_q[i % 36] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_pairs.size() != 0 || s_tvalid || harmonics_due.size() != 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && harmonics_due.size() == 0)
      $display("** spherical_harmonic_table: PASSED **");
    else
      $display("** spherical_harmonic_table: FAILED **");
    $finish;
  end

endmodule
